[rtl/nfba_pkg.sv]
// Shared types and constants for the next-fit block allocator.
// No dependencies; imported by nfba_cell, next_fit_block_allocator, nfba_result_checker and the testbench.
`timescale 1ns / 1ps

package nfba_pkg;

    // Defaults for the top-level parameters
    localparam int DEF_NUM_BLOCKS   = 16;
    localparam int DEF_AMOUNT_WIDTH = 16;

    // Fixed port field widths
    localparam int OP_W      = 2;
    localparam int INDEX_W   = 4;
    localparam int FIELD_W   = 16;
    localparam int STATUS_W  = 3;
    localparam int BCOUNT_W  = 5;

    localparam logic [BCOUNT_W-1:0] BCOUNT_RESET = 5'd16;

    // Request operation codes
    typedef enum logic [OP_W-1:0] {
        OP_LOAD    = 2'd0,
        OP_ALLOC   = 2'd1,
        OP_RELEASE = 2'd2
    } op_t;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_ALLOCATED    = 3'd0,
        ST_NO_FIT       = 3'd1,
        ST_RELEASED     = 3'd2,
        ST_ALREADY_FREE = 3'd3,
        ST_INVALID      = 3'd4,
        ST_LOADED       = 3'd5
    } status_t;

    // One result as presented on the output channel
    typedef struct packed {
        status_t              status;
        logic [INDEX_W-1:0]   blk;
        logic [FIELD_W-1:0]   rem;
        logic [FIELD_W-1:0]   cap;
    } res_t;

    // Per-cell control: rotate the ring, or overwrite the head entry
    typedef struct packed {
        logic shift;
        logic write;
    } cell_ctl_t;

endpackage

[rtl/next_fit_block_allocator.sv]
// Top level of the next-fit block allocator: request sequencer and a ring of cells.
// Depends on nfba_pkg and nfba_cell.
//
// Channel  Direction  Handshake            Payload
// in       input      in_valid / in_stall  operation, block_index, amount
// out      output     out_valid / out_stall status, chosen_block, remaining_left,
//                                          block_capacity
// cfg      input      cfg_valid / cfg_ready cfg_data (block_count)
//
// One request at a time. The ring rotates one cell per cycle until the target block
// sits at the head: load and release seek the target block, allocate seeks to the
// pointer and then scans, and invalid requests go straight to the result. A new
// request is taken while a result waits in the output register.
// Reset clears flags and pointer and sets each block tag to its cell index;
// capacities stay undefined until loaded.
`timescale 1ns / 1ps

module next_fit_block_allocator #(
    parameter int NUM_BLOCKS   = nfba_pkg::DEF_NUM_BLOCKS,
    parameter int AMOUNT_WIDTH = nfba_pkg::DEF_AMOUNT_WIDTH
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [nfba_pkg::OP_W-1:0]        operation,
    input  logic [nfba_pkg::INDEX_W-1:0]     block_index,
    input  logic [nfba_pkg::FIELD_W-1:0]     amount,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [nfba_pkg::STATUS_W-1:0]    status,
    output logic [nfba_pkg::INDEX_W-1:0]     chosen_block,
    output logic [nfba_pkg::FIELD_W-1:0]     remaining_left,
    output logic [nfba_pkg::FIELD_W-1:0]     block_capacity,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [nfba_pkg::BCOUNT_W-1:0]    cfg_data
);
    import nfba_pkg::*;

    localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int UW    = (AMOUNT_WIDTH < FIELD_W) ? AMOUNT_WIDTH : FIELD_W;
    localparam int CMP_W = IDX_W + 5;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SEEK = 4'b0010,
        S_SCAN = 4'b0100,
        S_EMIT = 4'b1000
    } state_t;

    state_t              state_reg, state_next;
    op_t                 op_reg, op_next;
    logic [UW-1:0]       amt_reg, amt_next;
    logic [IDX_W-1:0]    target_reg, target_next;
    logic [IDX_W-1:0]    cnt_reg, cnt_next;
    logic [IDX_W-1:0]    ptr_reg, ptr_next;
    logic [BCOUNT_W-1:0] bcount_reg, bcount_next;
    res_t                res_reg, res_next;
    res_t                out_reg;
    logic                out_valid_reg, out_valid_next;
    logic                out_load;

    // Ring wiring
    cell_ctl_t           head_ctl;
    logic                wr_flag;
    logic [UW-1:0]       wr_cap, wr_rem;
    logic [IDX_W-1:0]    c_id   [NUM_BLOCKS];
    logic                c_flag [NUM_BLOCKS];
    logic [UW-1:0]       c_cap  [NUM_BLOCKS];
    logic [UW-1:0]       c_rem  [NUM_BLOCKS];

    logic [CMP_W-1:0]    idx_ext, head_ext;
    logic                head_in_use, head_fits;
    logic [UW-1:0]       head_after;

    function automatic logic [FIELD_W-1:0] to_field(logic [UW-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        return w[FIELD_W-1:0];
    endfunction

    // Cell i takes from cell i+1, so block tags ascend past the head
    for (genvar i = 0; i < NUM_BLOCKS; i++)
    begin : g_cell
        localparam int NB = (i == NUM_BLOCKS - 1) ? 0 : i + 1;
        cell_ctl_t ctl;
        assign ctl.shift = head_ctl.shift;
        assign ctl.write = (i == 0) ? head_ctl.write : 1'b0;

        nfba_cell #(
            .IDX_W    (IDX_W),
            .AMT_W    (UW),
            .RESET_ID (i)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctl     (ctl),
            .nb_id   (c_id[NB]),
            .nb_flag (c_flag[NB]),
            .nb_cap  (c_cap[NB]),
            .nb_rem  (c_rem[NB]),
            .wr_flag (wr_flag),
            .wr_cap  (wr_cap),
            .wr_rem  (wr_rem),
            .id      (c_id[i]),
            .flag    (c_flag[i]),
            .cap     (c_cap[i]),
            .rem     (c_rem[i])
        );
    end

    // Head-cell tests
    assign idx_ext     = CMP_W'(block_index);
    assign head_ext    = CMP_W'(c_id[0]);
    assign head_in_use = head_ext < CMP_W'(bcount_reg);
    assign head_fits   = c_rem[0] >= amt_reg;
    assign head_after  = c_rem[0] - amt_reg;

    // Request sequencer
    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        amt_next       = amt_reg;
        target_next    = target_reg;
        cnt_next       = cnt_reg;
        ptr_next       = ptr_reg;
        res_next       = res_reg;
        head_ctl.shift = 1'b0;
        head_ctl.write = 1'b0;
        wr_flag        = c_flag[0];
        wr_cap         = c_cap[0];
        wr_rem         = c_rem[0];
        out_load       = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next     = op_t'(operation);
                    amt_next    = amount[UW-1:0];
                    target_next = (op_t'(operation) == OP_ALLOC) ? ptr_reg
                                                                 : idx_ext[IDX_W-1:0];
                    res_next    = '{status: ST_INVALID, blk: '0, rem: '0, cap: '0};
                    unique case (op_t'(operation))
                        OP_LOAD:
                            state_next = (idx_ext >= CMP_W'(NUM_BLOCKS)) ? S_EMIT : S_SEEK;
                        OP_ALLOC:
                            state_next = S_SEEK;
                        OP_RELEASE:
                            state_next = (idx_ext >= CMP_W'(NUM_BLOCKS) ||
                                          idx_ext >= CMP_W'(bcount_reg)) ? S_EMIT : S_SEEK;
                        default:
                            state_next = S_EMIT;
                    endcase
                end
            end

            S_SEEK:
            begin
                if (c_id[0] == target_reg)
                begin
                    unique case (op_reg)
                        OP_LOAD:
                        begin
                            head_ctl.write = 1'b1;
                            wr_flag        = 1'b0;
                            wr_cap         = amt_reg;
                            wr_rem         = amt_reg;
                            res_next       = '{status: ST_LOADED, blk: head_ext[INDEX_W-1:0],
                                               rem: to_field(amt_reg), cap: to_field(amt_reg)};
                            state_next     = S_EMIT;
                        end
                        OP_RELEASE:
                        begin
                            if (c_flag[0])
                            begin
                                head_ctl.write = 1'b1;
                                wr_flag        = 1'b0;
                                wr_rem         = c_cap[0];
                                res_next       = '{status: ST_RELEASED,
                                                   blk: head_ext[INDEX_W-1:0],
                                                   rem: to_field(c_cap[0]),
                                                   cap: to_field(c_cap[0])};
                            end
                            else
                            begin
                                res_next = '{status: ST_ALREADY_FREE,
                                             blk: head_ext[INDEX_W-1:0],
                                             rem: to_field(c_rem[0]),
                                             cap: to_field(c_cap[0])};
                            end
                            state_next = S_EMIT;
                        end
                        OP_ALLOC:
                        begin
                            cnt_next   = '0;
                            state_next = S_SCAN;
                        end
                        default:
                            state_next = S_EMIT;
                    endcase
                end
                else
                begin
                    head_ctl.shift = 1'b1;
                end
            end

            S_SCAN:
            begin
                if (head_in_use && head_fits)
                begin
                    head_ctl.write = 1'b1;
                    wr_flag        = 1'b1;
                    wr_rem         = head_after;
                    ptr_next       = c_id[0];
                    res_next       = '{status: ST_ALLOCATED, blk: head_ext[INDEX_W-1:0],
                                       rem: to_field(head_after), cap: to_field(c_cap[0])};
                    state_next     = S_EMIT;
                end
                else if (cnt_reg == IDX_W'(NUM_BLOCKS - 1))
                begin
                    res_next   = '{status: ST_NO_FIT, blk: '0, rem: '0, cap: '0};
                    state_next = S_EMIT;
                end
                else
                begin
                    head_ctl.shift = 1'b1;
                    cnt_next       = cnt_reg + 1'b1;
                end
            end

            S_EMIT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
                state_next = S_IDLE;
        endcase
    end

    // Block count register, written only while idle
    assign cfg_ready   = (state_reg == S_IDLE);
    assign bcount_next = (cfg_valid && cfg_ready) ? cfg_data : bcount_reg;

    assign out_valid_next = out_load ? 1'b1 : (out_stall ? out_valid_reg : 1'b0);

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ptr_reg       <= '0;
            cnt_reg       <= '0;
            bcount_reg    <= BCOUNT_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            cnt_reg       <= cnt_next;
            bcount_reg    <= bcount_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Request and result payload
    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        amt_reg    <= amt_next;
        target_reg <= target_next;
        res_reg    <= res_next;
        if (out_load)
        begin
            out_reg <= res_reg;
        end
    end

    assign in_stall       = (state_reg != S_IDLE);
    assign out_valid      = out_valid_reg;
    assign status         = out_reg.status;
    assign chosen_block   = out_reg.blk;
    assign remaining_left = out_reg.rem;
    assign block_capacity = out_reg.cap;

    // Checks
    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("sequencer state not one-hot");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg != S_IDLE))
        else $error("accepted request did not start");

    a_emit_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (out_valid && status == $past(res_reg.status)))
        else $error("result not presented after emit");

    a_ptr_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && head_ctl.write) |=> (ptr_reg == $past(c_id[0])))
        else $error("pointer not moved to allocated block");

    a_write_no_shift: assert property (@(posedge clk) disable iff (!rst_n)
        !(head_ctl.write && head_ctl.shift))
        else $error("head write during rotation");

endmodule

[rtl/nfba_cell.sv]
// One ring cell: holds a block tag, allocated flag, capacity and remaining amount.
// Depends on nfba_pkg (cell_ctl_t).
`timescale 1ns / 1ps

module nfba_cell #(
    parameter int IDX_W    = 4,
    parameter int AMT_W    = 16,
    parameter int RESET_ID = 0
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  nfba_pkg::cell_ctl_t   ctl,
    input  logic [IDX_W-1:0]      nb_id,
    input  logic                  nb_flag,
    input  logic [AMT_W-1:0]      nb_cap,
    input  logic [AMT_W-1:0]      nb_rem,
    input  logic                  wr_flag,
    input  logic [AMT_W-1:0]      wr_cap,
    input  logic [AMT_W-1:0]      wr_rem,
    output logic [IDX_W-1:0]      id,
    output logic                  flag,
    output logic [AMT_W-1:0]      cap,
    output logic [AMT_W-1:0]      rem
);
    import nfba_pkg::*;

    logic [IDX_W-1:0] id_reg, id_next;
    logic             flag_reg, flag_next;
    logic [AMT_W-1:0] cap_reg, cap_next;
    logic [AMT_W-1:0] rem_reg, rem_next;

    // Write has priority; a write keeps the tag in place
    always_comb
    begin
        id_next   = id_reg;
        flag_next = flag_reg;
        cap_next  = cap_reg;
        rem_next  = rem_reg;
        if (ctl.write)
        begin
            flag_next = wr_flag;
            cap_next  = wr_cap;
            rem_next  = wr_rem;
        end
        else if (ctl.shift)
        begin
            id_next   = nb_id;
            flag_next = nb_flag;
            cap_next  = nb_cap;
            rem_next  = nb_rem;
        end
    end

    // Tag and flag are control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            id_reg   <= IDX_W'(RESET_ID);
            flag_reg <= 1'b0;
        end
        else
        begin
            id_reg   <= id_next;
            flag_reg <= flag_next;
        end
    end

    // Amounts are payload, undefined until loaded
    always_ff @(posedge clk)
    begin
        cap_reg <= cap_next;
        rem_reg <= rem_next;
    end

    assign id   = id_reg;
    assign flag = flag_reg;
    assign cap  = cap_reg;
    assign rem  = rem_reg;

endmodule

[dv/nfba_result_checker.sv]
// Result checker for the next-fit block allocator: keeps a shadow of the block table,
// predicts the outcome of every accepted request and compares each returned result.
// Depends on nfba_pkg.
`timescale 1ns / 1ps

module nfba_result_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic                             in_stall,
    input  logic [nfba_pkg::OP_W-1:0]        operation,
    input  logic [nfba_pkg::INDEX_W-1:0]     block_index,
    input  logic [nfba_pkg::FIELD_W-1:0]     amount,
    input  logic                             out_valid,
    input  logic                             out_stall,
    input  logic [nfba_pkg::STATUS_W-1:0]    status,
    input  logic [nfba_pkg::INDEX_W-1:0]     chosen_block,
    input  logic [nfba_pkg::FIELD_W-1:0]     remaining_left,
    input  logic [nfba_pkg::FIELD_W-1:0]     block_capacity,
    input  logic                             cfg_valid,
    input  logic                             cfg_ready,
    input  logic [nfba_pkg::BCOUNT_W-1:0]    cfg_data,
    output int                               mismatches,
    output int                               outcomes_pending,
    output int                               outcomes_seen
);
    import nfba_pkg::*;

    localparam int NB = DEF_NUM_BLOCKS;
    localparam int MAX_PRINTED = 40;

    // Shadow of the allocator state
    logic [FIELD_W-1:0]  capacity_tab [NB];
    logic [FIELD_W-1:0]  remaining_tab [NB];
    logic                held_flag [NB];
    logic [INDEX_W-1:0]  fit_ptr;
    logic [BCOUNT_W-1:0] block_count_reg;

    res_t outcome_q [$];
    res_t oldest;

    task automatic flag_mismatch(input string msg);
        if (mismatches < MAX_PRINTED)
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        mismatches++;
    endtask

    // Next-fit outcome of one request; updates the shadow table
    function automatic res_t next_fit_outcome(input logic [OP_W-1:0] op,
                                              input logic [INDEX_W-1:0] idx,
                                              input logic [FIELD_W-1:0] amt);
        res_t r;
        int unsigned in_use;
        int unsigned start;
        int unsigned b;
        logic found;
        r = '0;
        r.status = ST_INVALID;
        in_use = (block_count_reg > NB) ? NB : block_count_reg;
        found = 1'b0;
        case (op)
            OP_LOAD:
            begin
                capacity_tab[idx]  = amt;
                remaining_tab[idx] = amt;
                held_flag[idx]     = 1'b0;
                r.status = ST_LOADED;
                r.blk    = idx;
                r.rem    = amt;
                r.cap    = amt;
            end
            OP_ALLOC:
            begin
                r.status = ST_NO_FIT;
                // stale pointer restarts the search at block zero
                start = (fit_ptr < in_use) ? fit_ptr : 0;
                for (int i = 0; i < NB; i++)
                begin
                    if (i < in_use && !found)
                    begin
                        b = start + i;
                        if (b >= in_use)
                            b = b - in_use;
                        if (remaining_tab[b] >= amt)
                        begin
                            found = 1'b1;
                            remaining_tab[b] = remaining_tab[b] - amt;
                            held_flag[b] = 1'b1;
                            fit_ptr  = INDEX_W'(b);
                            r.status = ST_ALLOCATED;
                            r.blk    = INDEX_W'(b);
                            r.rem    = remaining_tab[b];
                            r.cap    = capacity_tab[b];
                        end
                    end
                end
            end
            OP_RELEASE:
            begin
                if (idx < in_use)
                begin
                    if (held_flag[idx])
                    begin
                        remaining_tab[idx] = capacity_tab[idx];
                        held_flag[idx] = 1'b0;
                        r.status = ST_RELEASED;
                    end
                    else
                        r.status = ST_ALREADY_FREE;
                    r.blk = idx;
                    r.rem = remaining_tab[idx];
                    r.cap = capacity_tab[idx];
                end
            end
            default:
                r.status = ST_INVALID;
        endcase
        return r;
    endfunction

    // Watch the three channels
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int b = 0; b < NB; b++)
            begin
                capacity_tab[b]  = '0;
                remaining_tab[b] = '0;
                held_flag[b]     = 1'b0;
            end
            fit_ptr          = '0;
            block_count_reg  = BCOUNT_RESET;
            outcome_q.delete();
            mismatches       = 0;
            outcomes_seen    = 0;
            outcomes_pending <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                block_count_reg = cfg_data;

            // returned result against the oldest prediction
            if (out_valid && !out_stall)
            begin
                outcomes_seen++;
                if (outcome_q.size() == 0)
                    flag_mismatch($sformatf("result status %0d with no request waiting",
                                            status));
                else
                begin
                    oldest = outcome_q.pop_front();
                    if (status !== oldest.status)
                        flag_mismatch($sformatf("status got %0d want %0d",
                                                status, oldest.status));
                    if (chosen_block !== oldest.blk)
                        flag_mismatch($sformatf("chosen_block got %0d want %0d",
                                                chosen_block, oldest.blk));
                    if (remaining_left !== oldest.rem)
                        flag_mismatch($sformatf("remaining_left got %0d want %0d",
                                                remaining_left, oldest.rem));
                    if (block_capacity !== oldest.cap)
                        flag_mismatch($sformatf("block_capacity got %0d want %0d",
                                                block_capacity, oldest.cap));
                end
            end

            if (in_valid && !in_stall)
                outcome_q.push_back(next_fit_outcome(operation, block_index, amount));

            outcomes_pending <= outcome_q.size();
        end
    end

endmodule

[dv/tb_next_fit_block_allocator.sv]
// Testbench top for the next-fit block allocator: clock, reset, request stimulus,
// output stalls, block_count phases, watchdog and verdict.
// Depends on nfba_pkg, next_fit_block_allocator and nfba_result_checker.
`timescale 1ns / 1ps

module tb_next_fit_block_allocator;
    import nfba_pkg::*;

    localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;
    localparam int IDLE_LIMIT  = 4000;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN       = 40;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [OP_W-1:0]     operation = '0;
    logic [INDEX_W-1:0]  block_index = '0;
    logic [FIELD_W-1:0]  amount = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [STATUS_W-1:0] status;
    logic [INDEX_W-1:0]  chosen_block;
    logic [FIELD_W-1:0]  remaining_left;
    logic [FIELD_W-1:0]  block_capacity;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [BCOUNT_W-1:0] cfg_data = '0;

    int mismatches;
    int outcomes_pending;
    int outcomes_seen;

    int unsigned live_blocks = 16;
    int requests_sent = 0;
    int cfg_writes = 0;
    int idle_cycles = 0;
    bit quiet_tail = 1'b0;
    bit hold_pending = 1'b0;
    bit hold_served = 1'b0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    next_fit_block_allocator u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .operation      (operation),
        .block_index    (block_index),
        .amount         (amount),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .chosen_block   (chosen_block),
        .remaining_left (remaining_left),
        .block_capacity (block_capacity),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data)
    );

    nfba_result_checker u_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .operation        (operation),
        .block_index      (block_index),
        .amount           (amount),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .status           (status),
        .chosen_block     (chosen_block),
        .remaining_left   (remaining_left),
        .block_capacity   (block_capacity),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data),
        .mismatches       (mismatches),
        .outcomes_pending (outcomes_pending),
        .outcomes_seen    (outcomes_seen)
    );

    // Offer one request and wait for it to be taken; sometimes a random gap afterwards
    task automatic send_req(input logic [OP_W-1:0] op, input logic [INDEX_W-1:0] idx,
                            input logic [FIELD_W-1:0] amt);
        operation   <= op;
        block_index <= idx;
        amount      <= amt;
        in_valid    <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        requests_sent++;
        if (!quiet_tail && $urandom_range(2, 0) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(18, 1))
                @(posedge clk);
        end
    endtask

    // Change block_count once every outstanding result is back
    task automatic write_block_count(input logic [BCOUNT_W-1:0] value);
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (outcomes_pending != 0);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        live_blocks = (value > 16) ? 16 : value;
        cfg_writes++;
    endtask

    // Mostly well-formed traffic: allocations sized to fit, releases of blocks in use
    task automatic send_random_req();
        int unsigned pick;
        logic [OP_W-1:0] op;
        logic [INDEX_W-1:0] idx;
        logic [FIELD_W-1:0] amt;
        pick = $urandom_range(99, 0);
        idx  = INDEX_W'($urandom_range(15, 0));
        amt  = FIELD_W'($urandom);
        if (pick < 25)
        begin
            op = OP_LOAD;
            if ($urandom_range(3, 0) != 0)
                amt = FIELD_W'($urandom_range(20000, 500));
        end
        else if (pick < 70)
        begin
            op = OP_ALLOC;
            case ($urandom_range(9, 0))
                0: amt = '0;
                1: amt = '1;
                2, 3: ;
                default: amt = FIELD_W'($urandom_range(3000, 1));
            endcase
        end
        else if (pick < 95)
        begin
            op = OP_RELEASE;
            if (live_blocks != 0 && $urandom_range(4, 0) != 0)
                idx = INDEX_W'($urandom_range(live_blocks - 1, 0));
        end
        else
            op = OP_RESERVED;
        send_req(op, idx, amt);
    endtask

    // Receiver: random stall bursts, free-running stretches, one long hold-off
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_pending && !hold_served)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES)
                    @(posedge clk);
                hold_served = 1'b1;
                out_stall <= 1'b0;
            end
            else if (quiet_tail)
                out_stall <= 1'b0;
            else if ($urandom_range(2, 0) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(18, 1))
                    @(posedge clk);
                out_stall <= 1'b0;
            end
            else
            begin
                out_stall <= 1'b0;
                repeat ($urandom_range(20, 0))
                    @(posedge clk);
            end
        end
    end

    // Watchdog: too long without any handshake
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall)
                || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Watchdog: no handshake for %0d cycles", idle_cycles);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // Stimulus
    initial
    begin
        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_block_count(5'd16);

        // fill every block so no unwritten entry is ever read
        for (int i = 0; i < 16; i++)
            send_req(OP_LOAD, INDEX_W'(i),
                     (i == 0) ? 16'h0000 : (i == 1) ? 16'hFFFF : FIELD_W'(i * 1000));

        // zero request fits the empty block, full-size request, no fit
        send_req(OP_ALLOC, 4'd0, 16'd0);
        send_req(OP_ALLOC, 4'd0, 16'hFFFF);
        send_req(OP_ALLOC, 4'd15, 16'hFFFF);
        send_req(OP_ALLOC, 4'd0, 16'd1500);
        // release, then release of a block already free
        send_req(OP_RELEASE, 4'd1, 16'hFFFF);
        send_req(OP_RELEASE, 4'd1, 16'd0);
        send_req(OP_RELEASE, 4'd15, 16'd0);
        send_req(OP_RESERVED, 4'd15, 16'hFFFF);

        // no block in use; load still accepted
        write_block_count(5'd0);
        send_req(OP_ALLOC, 4'd0, 16'd0);
        send_req(OP_RELEASE, 4'd0, 16'd0);
        send_req(OP_LOAD, 4'd15, 16'hAAAA);

        // single block: stale pointer restarts at zero, release past the count
        write_block_count(5'd1);
        send_req(OP_ALLOC, 4'd0, 16'd0);
        send_req(OP_RELEASE, 4'd1, 16'd0);

        // count above the table size saturates
        write_block_count(5'd31);
        send_req(OP_ALLOC, 4'd0, 16'h5555);
        send_req(OP_RELEASE, 4'd15, 16'd0);

        // random phases over several block counts
        write_block_count(5'd16);
        for (int n = 0; n < 150; n++)
        begin
            if (n == 30)
                hold_pending = 1'b1;
            send_random_req();
        end

        write_block_count(5'd1);
        repeat (60)
            send_random_req();

        write_block_count(BCOUNT_W'($urandom_range(15, 2)));
        repeat (130)
            send_random_req();

        write_block_count(5'd31);
        repeat (120)
            send_random_req();

        write_block_count(5'd0);
        repeat (30)
            send_random_req();

        write_block_count(BCOUNT_W'($urandom_range(30, 17)));
        repeat (120)
            send_random_req();

        // last stretch runs without idling on either side
        write_block_count(5'd16);
        quiet_tail = 1'b1;
        repeat (140)
            send_random_req();

        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (outcomes_pending != 0);
        repeat (DRAIN)
            @(posedge clk);

        $display("Covered %0d requests and %0d results over %0d block_count writes",
                 requests_sent, outcomes_seen, cfg_writes);
        $display("(counts 0, 1, 16, saturated and random; one long output hold-off)");
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

[next_fit_block_allocator.f]
rtl/nfba_pkg.sv
rtl/nfba_cell.sv
rtl/next_fit_block_allocator.sv
dv/nfba_result_checker.sv
dv/tb_next_fit_block_allocator.sv
